@@ rtl/core/mrp_pkg.sv @@
package mrp_pkg;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STRIP,
    ST_MOD,
    ST_POW_CHK,
    ST_MUL,
    ST_POW_NEXT,
    ST_SQ_CHK,
    ST_DONE
  } mrp_state_t;

  // what the shared multiplier result feeds
  typedef enum logic [1:0] {
    MUL_ACC,
    MUL_BASE,
    MUL_SQ
  } mrp_mul_t;

  localparam int unsigned CandWidth = 32;
  localparam int unsigned RandWidth = 31;

endpackage

@@ rtl/core/miller_rabin_primality_core.sv @@
// Channel | Dir | tdata bits                         | tuser
// in_     | in  | [31:0] candidate, [62:32] random   | last_round
// out_    | out | [0] probably_prime (zero padded)   | -
//
// A round strips the twos from n-1, reduces the random value modulo n-3 by restoring
// subtraction, then exponentiates and squares on the single shift-add modular
// multiplier: one product per bit of d plus one per set bit, then up to s-1
// squarings. The witness reduction has its own subtractor, apart from the multiplier.
// Small and even candidates go straight to the verdict. Reset is synchronous, active
// low, and sets the sticky pass flag. The input is not ready while a round runs
// or while a verdict waits in the output register.
module miller_rabin_primality_core #(
  parameter int unsigned NUMBER_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] candidate, [62:32] random_value
  input  logic        in_tuser,   // [0] last_round
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [0] probably_prime
);
  import mrp_pkg::*;

  localparam int unsigned W  = NUMBER_WIDTH;
  localparam int unsigned RW = RandWidth;
  localparam int unsigned CW = $clog2(((W > RW) ? W : RW) + 1);

  mrp_state_t state_r, state_nxt;
  mrp_mul_t   mtyp_r;

  logic [W-1:0]  n_r, nm1_r, d_r, acc_r, base_r, ma_r, mb_r, mp_r, rem_r;
  logic [RW-1:0] rnd_r;
  logic [CW-1:0] cnt_r, s_r;
  logic          last_r, pass_r, outv_r, outd_r;

  // candidate masked to NUMBER_WIDTH
  logic [W-1:0] in_n;
  always_comb begin
    in_n = '0;
    for (int i = 0; i < W; i++) begin
      if (i < CandWidth) in_n[i] = in_tdata[i];
    end
  end

  // shared add-mod step: (x + y) mod n, x,y < n
  function automatic logic [W-1:0] addm(logic [W-1:0] x, logic [W-1:0] y,
                                        logic [W-1:0] m);
    logic [W-1:0] gap;
    gap = m - y;
    return (x >= gap) ? x - gap : x + y;
  endfunction

  logic [W-1:0] dbl, mstep;
  always_comb begin
    dbl   = addm(mp_r, mp_r, n_r);
    mstep = mb_r[W-1] ? addm(dbl, ma_r, n_r) : dbl;
  end

  // restoring mod step for the witness: rem = (rem*2 + bit) mod (n-3)
  logic [W:0]   rsh;
  logic [W-1:0] nm3, rem_nxt;
  assign nm3 = n_r - W'(3);
  assign rsh = {rem_r, rnd_r[RW-1]};
  assign rem_nxt = (rsh >= {1'b0, nm3}) ? W'(rsh - {1'b0, nm3}) : rsh[W-1:0];

  assign in_tready = (state_r == ST_IDLE) && !outv_r;
  wire acc_in = in_tvalid && in_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (acc_in) begin
        if (in_n <= W'(3) || !in_n[0]) state_nxt = ST_DONE;
        else state_nxt = ST_STRIP;
      end
      ST_STRIP:    if (d_r[0]) state_nxt = ST_MOD;
      ST_MOD:      if (cnt_r == CW'(1)) state_nxt = ST_POW_CHK;
      ST_POW_CHK:  state_nxt = (d_r == '0) ? ST_SQ_CHK : ST_MUL;
      ST_MUL:      if (cnt_r == CW'(1)) begin
        state_nxt = (mtyp_r == MUL_SQ) ? ST_SQ_CHK :
                    (mtyp_r == MUL_ACC) ? ST_MUL : ST_POW_NEXT;
      end
      ST_POW_NEXT: state_nxt = ST_POW_CHK;
      ST_SQ_CHK:   if (acc_r == nm1_r || (s_r == '0) || acc_r == W'(1))
                     state_nxt = ST_DONE;
                   else state_nxt = ST_MUL;
      ST_DONE:     state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // round result, computed when leaving the square check or on a direct case
  logic round_ok_r;

  // datapath and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_r <= 1'b1;
      outv_r <= 1'b0;
      outd_r <= 1'b0;
    end else begin
      if (outv_r && out_tready) outv_r <= 1'b0;
      case (state_r)
        ST_IDLE: if (acc_in) begin
          n_r    <= in_n;
          nm1_r  <= in_n - W'(1);
          d_r    <= in_n - W'(1);
          rnd_r  <= in_tdata[62:32];
          last_r <= in_tuser;
          s_r    <= '0;
          rem_r  <= '0;
          round_ok_r <= (in_n == W'(2)) || (in_n == W'(3));
        end
        ST_STRIP: begin
          if (!d_r[0]) begin
            d_r <= d_r >> 1;
            s_r <= s_r + CW'(1);
          end else cnt_r <= CW'(RW);
        end
        ST_MOD: begin
          rem_r <= rem_nxt;
          rnd_r <= rnd_r << 1;
          cnt_r <= cnt_r - CW'(1);
          acc_r <= W'(1);
          // witness loads the base once reduction ends
          if (cnt_r == CW'(1)) begin
            base_r <= rem_nxt + W'(2);
            mtyp_r <= MUL_ACC;
          end
        end
        ST_POW_CHK: begin
          if (d_r == '0) begin
            // power done: s counts the s-1 squarings left
            s_r <= s_r - CW'(1);
            round_ok_r <= 1'b0;
          end else begin
            mp_r  <= '0;
            ma_r  <= base_r;
            mb_r  <= d_r[0] ? acc_r : base_r;
            mtyp_r <= d_r[0] ? MUL_ACC : MUL_BASE;
            cnt_r <= CW'(W);
          end
        end
        ST_MUL: begin
          if (cnt_r == CW'(1)) begin
            case (mtyp_r)
              MUL_ACC: begin
                acc_r  <= mstep;
                mp_r   <= '0;
                ma_r   <= base_r;
                mb_r   <= base_r;
                mtyp_r <= MUL_BASE;
                cnt_r  <= CW'(W);
              end
              MUL_BASE: base_r <= mstep;
              MUL_SQ:   acc_r  <= mstep;
              default:  acc_r  <= mstep;
            endcase
          end else begin
            mp_r  <= mstep;
            mb_r  <= mb_r << 1;
            cnt_r <= cnt_r - CW'(1);
          end
        end
        ST_POW_NEXT: d_r <= d_r >> 1;
        ST_SQ_CHK: begin
          if (acc_r == nm1_r) round_ok_r <= 1'b1;
          else if (acc_r == W'(1)) round_ok_r <= (d_r == '0) && (mtyp_r != MUL_SQ);
          else if (s_r != '0) begin
            s_r    <= s_r - CW'(1);
            mp_r   <= '0;
            ma_r   <= acc_r;
            mb_r   <= acc_r;
            mtyp_r <= MUL_SQ;
            cnt_r  <= CW'(W);
          end
        end
        ST_DONE: begin
          if (last_r) begin
            outv_r <= 1'b1;
            outd_r <= pass_r & round_ok_r;
            pass_r <= 1'b1;
          end else pass_r <= pass_r & round_ok_r;
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = outv_r;
  assign out_tdata  = {7'b0, outd_r};

  // assertions
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready) else $error("ready while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid) else $error("verdict dropped");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_DONE)) else $error("stray verdict");

endmodule

@@ test/tb_miller_rabin_primality_core.sv @@
module tb_miller_rabin_primality_core;

  localparam int unsigned StallLimit = 40000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // [31:0] candidate, [62:32] random_value, [63] zero
  logic        in_tuser;   // [0] last_round
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [0] probably_prime, [7:1] zero

  typedef struct packed {
    logic [31:0] cand;
    logic [30:0] rnd;
    logic        last;
  } round_word_t;

  round_word_t pending_rounds[$];
  logic        verdicts_due[$];
  logic        sticky_pass;
  logic        in_taken;
  int          err_count;
  int          idle_cycles;
  int          burst_left;
  int          gap_left;

  miller_rabin_primality_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // (a*b) mod m, shift-add from the top bit
  function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [64:0] acc;
    acc = '0;
    for (int i = 63; i >= 0; i--) begin
      acc = acc << 1;
      if (acc >= {1'b0, m}) acc = acc - m;
      if (b[i]) begin
        acc = acc + a;
        if (acc >= {1'b0, m}) acc = acc - m;
      end
    end
    return acc[63:0];
  endfunction

  function automatic logic round_passes(logic [31:0] cand, logic [30:0] rnd);
    logic [63:0] n, nm1, d, a, x, base, e;
    int s;
    n = cand;
    if (n <= 1) return 1'b0;
    if (n <= 3) return 1'b1;
    if (!n[0]) return 1'b0;
    nm1 = n - 1;
    d = nm1;
    s = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    a = 2 + (64'(rnd) % (n - 3));
    x = 1;
    base = a;
    e = d;
    while (e != 0) begin
      if (e[0]) x = mulmod(x, base, n);
      base = mulmod(base, base, n);
      e = e >> 1;
    end
    if (x == 1 || x == nm1) return 1'b1;
    for (int i = 1; i < s; i++) begin
      x = mulmod(x, x, n);
      if (x == nm1) return 1'b1;
      if (x == 1) return 1'b0;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    err_count++;
  endtask

  task automatic add_test(logic [31:0] cand, int rounds);
    round_word_t w;
    for (int r = 0; r < rounds; r++) begin
      w.cand = cand;
      w.rnd  = 31'($urandom);
      w.last = (r == rounds - 1);
      pending_rounds.push_back(w);
    end
  endtask

  function automatic logic [31:0] rand_odd_small();
    return 32'($urandom_range(5, 4095)) | 32'd1;
  endfunction

  // driver: bursts with random gaps, updated at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pending_rounds.size() > 0) begin
        in_tdata  <= {1'b0, pending_rounds[0].rnd, pending_rounds[0].cand};
        in_tuser  <= pending_rounds[0].last;
        in_tvalid <= 1'b1;
        void'(pending_rounds.pop_front());
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(0, 6);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    // receiver stall pattern
    out_tready <= ($urandom_range(0, 7) < 5);
  end

  // monitor and predictor at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      sticky_pass <= 1'b1;
      idle_cycles <= 0;
      in_taken    <= 1'b0;
    end else begin
      logic acc_in, acc_out, pass_now;
      acc_in  = in_tvalid && in_tready;
      acc_out = out_tvalid && out_tready;
      in_taken <= acc_in;
      if (acc_in) begin
        pass_now = sticky_pass & round_passes(in_tdata[31:0], in_tdata[62:32]);
        if (in_tuser) begin
          verdicts_due.push_back(pass_now);
          sticky_pass <= 1'b1;
        end else begin
          sticky_pass <= pass_now;
        end
      end
      if (acc_out) begin
        if (verdicts_due.size() == 0) report_mismatch("verdict with none expected");
        else begin
          if (out_tdata[0] !== verdicts_due[0])
            report_mismatch($sformatf("probably_prime %b expected %b",
                                      out_tdata[0], verdicts_due[0]));
          if (out_tdata[7:1] !== 7'd0) report_mismatch("nonzero padding in out_tdata");
          void'(verdicts_due.pop_front());
        end
      end
      if (acc_in || acc_out) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("miller_rabin_primality_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] extremes[13];
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    err_count = 0;
    burst_left = 0;
    gap_left = 0;
    extremes = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd9,
                 32'hFFFF_FFFF, 32'hFFFF_FFFB, 32'hFFFF_FFFE, 32'h8000_0001, 32'd561};
    // directed: small, even, large extremes, one round each
    foreach (extremes[i]) add_test(extremes[i], 1);
    // random value extremes on a prime with large s (97 = 1+3*2^5)
    pending_rounds.push_back('{32'd97, 31'd0, 1'b0});
    pending_rounds.push_back('{32'd97, 31'h7FFF_FFFF, 1'b1});
    // sticky flag over changing candidates: pass then fail then verdict
    pending_rounds.push_back('{32'd13, 31'h5555_5555, 1'b0});
    pending_rounds.push_back('{32'd15, 31'h2AAA_AAAA, 1'b0});
    pending_rounds.push_back('{32'd3, 31'd1, 1'b1});
    // flag restored after verdict
    add_test(32'd65537, 3);
    add_test(32'd2147483647, 2);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // random tests: mostly small odd candidates, few full width
    while (pending_rounds.size() < 180) begin
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) add_test(rand_odd_small(), $urandom_range(1, 3));
      else if (pick < 8) add_test(32'($urandom_range(0, 64)), $urandom_range(1, 2));
      else add_test($urandom | 32'd1, 1);
    end
    wait (pending_rounds.size() == 0 && !in_tvalid);
    wait (verdicts_due.size() == 0);
    repeat (50) @(posedge clk);
    if (err_count == 0) $display("miller_rabin_primality_core verification clean");
    else $display("miller_rabin_primality_core verification failed");
    $finish;
  end

endmodule
